>>> src/rbpfc_pkg.sv
// shared types, codes and depth tables for the rectangle blit format converter
package rbpfc_pkg;

  // largest byte offset, both offsets saturate here
  localparam logic [26:0] OffsetMax = 27'd134217727;

  // conversion codes, 9..15 are unsupported
  typedef enum logic [3:0] {
    CONV_COPY_RGB   = 4'd0,
    CONV_COPY_RGBA  = 4'd1,
    CONV_COPY_A8    = 4'd2,
    CONV_RGBA_DROP  = 4'd3,
    CONV_RGBA_BLEND = 4'd4,
    CONV_RGB_OPAQUE = 4'd5,
    CONV_RGB_REAL   = 4'd6,
    CONV_RGB_ALPHA  = 4'd7,
    CONV_A8_RGBA    = 4'd8
  } conv_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CONVERT_SELECT = 3'd0,
    CFG_ORIGIN_X       = 3'd1,
    CFG_ORIGIN_Y       = 3'd2,
    CFG_DEST_WIDTH     = 3'd3,
    CFG_RECT_WIDTH     = 3'd4,
    CFG_RECT_HEIGHT    = 3'd5,
    CFG_SRC_STRIDE     = 3'd6,
    CFG_FLIP_Y         = 3'd7
  } cfg_reg_e;

  // load enables of the blend pipeline stages
  typedef struct packed {
    logic st2;
    logic st3;
  } pipe_en_t;

  // destination bytes per pixel
  function automatic logic [2:0] dest_depth(input logic [3:0] sel);
    logic [2:0] r;
    r = 3'd1;
    unique case (sel)
      CONV_COPY_RGB, CONV_RGBA_DROP, CONV_RGBA_BLEND: r = 3'd3;
      CONV_COPY_A8:                                   r = 3'd1;
      CONV_COPY_RGBA, CONV_RGB_OPAQUE, CONV_RGB_REAL,
      CONV_RGB_ALPHA, CONV_A8_RGBA:                   r = 3'd4;
      default:                                        r = 3'd1;
    endcase
    return r;
  endfunction

  // source bytes per pixel
  function automatic logic [2:0] src_depth(input logic [3:0] sel);
    logic [2:0] r;
    r = 3'd1;
    unique case (sel)
      CONV_COPY_RGB, CONV_RGB_OPAQUE, CONV_RGB_REAL,
      CONV_RGB_ALPHA:                                 r = 3'd3;
      CONV_COPY_RGBA, CONV_RGBA_DROP, CONV_RGBA_BLEND: r = 3'd4;
      CONV_COPY_A8, CONV_A8_RGBA:                     r = 3'd1;
      default:                                        r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

>>> src/rbpfc_blend_chan.sv
// one color channel of the alpha blend, d + trunc((s - d) * a / 255)
module rbpfc_blend_chan import rbpfc_pkg::*; (
  input  logic       clk_i,
  input  pipe_en_t   en_i,
  input  logic [7:0] src_i,
  input  logic [7:0] dst_i,
  input  logic [7:0] alpha_i,
  output logic [7:0] res_o
);

  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic [17:0]        prod_abs;
  logic [31:0]        recip;

  logic        neg2_q, neg3_q;
  logic [15:0] mag2_q;
  logic [7:0]  dst2_q, dst3_q, quo3_q;

  assign diff     = $signed({1'b0, src_i}) - $signed({1'b0, dst_i});
  assign prod     = diff * $signed({1'b0, alpha_i});
  assign prod_abs = prod[17] ? 18'(-prod) : 18'(prod);
  // x / 255 for 16 bit x by reciprocal multiply
  assign recip    = 32'(mag2_q) * 32'h0000_8081;

  always_ff @(posedge clk_i) begin
    if (en_i.st2) begin
      neg2_q <= prod[17];
      mag2_q <= prod_abs[15:0];
      dst2_q <= dst_i;
    end
    if (en_i.st3) begin
      neg3_q <= neg2_q;
      quo3_q <= recip[30:23];
      dst3_q <= dst2_q;
    end
  end

  assign res_o = neg3_q ? (dst3_q - quo3_q) : (dst3_q + quo3_q);

endmodule

>>> src/rect_blit_pixel_format_convert.sv
// top level of the rectangle blit with pixel format conversion
//
// takes one source pixel word per clock when in_stall_o is low, in raster
// order over the rectangle and returns one result word per supported pixel:
// destination and source byte offsets, the converted bytes and the
// destination depth. the block is a four stage pipeline: the accept stage
// updates the column and row counters and registers the pixel, the second
// stage holds the two offset products and the blend products, the third the
// offset sums and the reciprocal multiply of the blend, and the output
// register the scaled and saturated offsets. the sustained rate is one word
// per clock while the output is not stalled; a stall on the output holds
// every full stage up to the first empty one, so bubbles are squeezed out.
// an item taken while convert_select is unsupported gives no word and leaves
// the counters alone. the only state carried from pixel to pixel is the pair
// of counters, cleared by reset and wrapped after the last pixel.
// configuration writes go straight to the registers and are meant for an
// idle block.
module rect_blit_pixel_format_convert_core import rbpfc_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  // pixel input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  src_b0_i,
  input  logic [7:0]  src_b1_i,
  input  logic [7:0]  src_b2_i,
  input  logic [7:0]  src_b3_i,
  input  logic [7:0]  dst_b0_i,
  input  logic [7:0]  dst_b1_i,
  input  logic [7:0]  dst_b2_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [26:0] dest_offset_o,
  output logic [26:0] src_offset_o,
  output logic [7:0]  out_b0_o,
  output logic [7:0]  out_b1_o,
  output logic [7:0]  out_b2_o,
  output logic [7:0]  out_b3_o,
  output logic [2:0]  byte_count_o,
  output logic        last_o
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int SP_W  = IDX_W + 15;  // source row product
  localparam int SS_W  = IDX_W + 16;  // source offset sum
  localparam logic [14:0] MaxDim = 15'(MAX_DIM);

  // rectangle size 0 acts as 1, above the limit acts as the limit
  function automatic logic [12:0] clamp_dim(input logic [12:0] v);
    logic [12:0] r;
    r = v;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if ({2'b00, v} > MaxDim) begin
      r = MaxDim[12:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [3:0]  conv_sel_q;
  logic [12:0] origin_x_q, origin_y_q, dest_width_q, rect_width_q, rect_height_q;
  logic [14:0] src_stride_q;
  logic        flip_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_sel_q    <= CONV_COPY_RGB;
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      dest_width_q  <= 13'd1;
      rect_width_q  <= 13'd1;
      rect_height_q <= 13'd1;
      src_stride_q  <= '0;
      flip_y_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CONVERT_SELECT: conv_sel_q    <= cfg_data_i[3:0];
        CFG_ORIGIN_X:       origin_x_q    <= cfg_data_i[12:0];
        CFG_ORIGIN_Y:       origin_y_q    <= cfg_data_i[12:0];
        CFG_DEST_WIDTH:     dest_width_q  <= cfg_data_i[12:0];
        CFG_RECT_WIDTH:     rect_width_q  <= cfg_data_i[12:0];
        CFG_RECT_HEIGHT:    rect_height_q <= cfg_data_i[12:0];
        CFG_SRC_STRIDE:     src_stride_q  <= cfg_data_i;
        CFG_FLIP_Y:         flip_y_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic en1, en2, en3, en_out;
  logic accept, supported;

  assign en_out     = !out_valid_q || !out_stall_i;
  assign en3        = !v3_q || en_out;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;
  assign supported  = (conv_sel_q <= 4'(CONV_A8_RGBA));

  // accept stage: position of this pixel and counter update
  logic [IDX_W-1:0] col_cnt_q, row_cnt_q;
  logic [12:0]      w_c, h_c;
  logic [13:0]      wm1, hm1;
  logic             last_col, last_row;
  logic [IDX_W-1:0] col_sel, row_sel, srow, col_nxt, row_nxt;
  logic [2:0]       dd_acc;
  logic [14:0]      w_scaled, stride;
  logic [13:0]      ycoord;
  logic [3:0][7:0]  bytes_acc;

  always_comb begin
    w_c      = clamp_dim(rect_width_q);
    h_c      = clamp_dim(rect_height_q);
    wm1      = {1'b0, w_c} - 14'd1;
    hm1      = {1'b0, h_c} - 14'd1;
    last_col = 14'(col_cnt_q) >= wm1;
    last_row = 14'(row_cnt_q) >= hm1;
    col_sel  = last_col ? wm1[IDX_W-1:0] : col_cnt_q;
    row_sel  = last_row ? hm1[IDX_W-1:0] : row_cnt_q;
    // flipped rows count down from the bottom of the rectangle
    srow     = flip_y_q ? (hm1[IDX_W-1:0] - row_sel) : row_sel;
    ycoord   = 14'(origin_y_q) + 14'(row_sel);
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_sel + 1'b1;
    end else begin
      col_nxt = col_sel + 1'b1;
      row_nxt = row_sel;
    end

    // default stride is rect width times destination depth
    dd_acc = dest_depth(conv_sel_q);
    unique case (dd_acc)
      3'd3:    w_scaled = 15'(w_c) + {1'b0, w_c, 1'b0};
      3'd4:    w_scaled = {w_c, 2'b00};
      default: w_scaled = 15'(w_c);
    endcase
    stride = (src_stride_q != 15'd0) ? src_stride_q : w_scaled;

    // converted bytes, the blend keeps the raw source bytes for later
    bytes_acc = '0;
    unique case (conv_sel_q)
      CONV_COPY_RGB, CONV_RGBA_DROP: begin
        bytes_acc[0] = src_b0_i;
        bytes_acc[1] = src_b1_i;
        bytes_acc[2] = src_b2_i;
      end
      CONV_COPY_RGBA, CONV_RGBA_BLEND: begin
        bytes_acc = {src_b3_i, src_b2_i, src_b1_i, src_b0_i};
      end
      CONV_COPY_A8: begin
        bytes_acc[0] = src_b0_i;
      end
      CONV_RGB_OPAQUE: begin
        bytes_acc = {8'hFF, src_b2_i, src_b1_i, src_b0_i};
      end
      CONV_RGB_REAL: begin
        // opaque only when some color byte is set
        bytes_acc[0] = src_b0_i;
        bytes_acc[1] = src_b1_i;
        bytes_acc[2] = src_b2_i;
        bytes_acc[3] = ((src_b0_i | src_b1_i | src_b2_i) != 8'h00) ? 8'hFF : 8'h00;
      end
      default: begin
        // white with the first source byte as alpha
        bytes_acc = {src_b0_i, 8'hFF, 8'hFF, 8'hFF};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (accept && supported) begin
      col_cnt_q <= col_nxt;
      row_cnt_q <= row_nxt;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    v1_q        <= accept && supported;
      if (en2)    v2_q        <= v1_q;
      if (en3)    v3_q        <= v2_q;
      if (en_out) out_valid_q <= v3_q;
    end
  end

  // stage 1 payload
  logic [3:0]       conv1_q;
  logic [IDX_W-1:0] col1_q, srow1_q;
  logic [13:0]      ycoord1_q;
  logic [14:0]      stride1_q;
  logic [3:0][7:0]  bytes1_q;
  logic [2:0][7:0]  dst1_q;
  logic             last1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      conv1_q   <= conv_sel_q;
      col1_q    <= col_sel;
      srow1_q   <= srow;
      ycoord1_q <= ycoord;
      stride1_q <= stride;
      bytes1_q  <= bytes_acc;
      dst1_q    <= {dst_b2_i, dst_b1_i, dst_b0_i};
      last1_q   <= last_col && last_row;
    end
  end

  // stage 2: row products
  logic [26:0]      prod_d2_q;
  logic [SP_W-1:0]  prod_s2_q;
  logic [IDX_W-1:0] col2_q;
  logic [2:0]       dd2_q, sd2_q;
  logic [3:0][7:0]  bytes2_q;
  logic             blend2_q, last2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod_d2_q <= 27'(ycoord1_q) * 27'(dest_width_q);
      prod_s2_q <= SP_W'(srow1_q) * SP_W'(stride1_q);
      col2_q    <= col1_q;
      dd2_q     <= dest_depth(conv1_q);
      sd2_q     <= src_depth(conv1_q);
      bytes2_q  <= bytes1_q;
      blend2_q  <= (conv1_q == 4'(CONV_RGBA_BLEND));
      last2_q   <= last1_q;
    end
  end

  // stage 3: offset sums
  logic [15:0]     col_scaled;
  logic [27:0]     dsum3_q;
  logic [SS_W-1:0] ssum3_q;
  logic [2:0]      dd3_q;
  logic [3:0][7:0] bytes3_q;
  logic            blend3_q, last3_q;

  always_comb begin
    unique case (sd2_q)
      3'd3:    col_scaled = 16'(col2_q) + 16'({col2_q, 1'b0});
      3'd4:    col_scaled = 16'({col2_q, 2'b00});
      default: col_scaled = 16'(col2_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      dsum3_q  <= 28'(prod_d2_q) + 28'(origin_x_q) + 28'(col2_q);
      ssum3_q  <= SS_W'(prod_s2_q) + SS_W'(col_scaled);
      dd3_q    <= dd2_q;
      bytes3_q <= bytes2_q;
      blend3_q <= blend2_q;
      last3_q  <= last2_q;
    end
  end

  // blend channels run alongside stages 2 and 3
  pipe_en_t        blend_en;
  logic [2:0][7:0] blend_res;

  assign blend_en.st2 = en2;
  assign blend_en.st3 = en3;

  for (genvar c = 0; c < 3; c++) begin : g_blend
    rbpfc_blend_chan u_chan (
      .clk_i   (clk_i),
      .en_i    (blend_en),
      .src_i   (bytes1_q[c]),
      .dst_i   (dst1_q[c]),
      .alpha_i (bytes1_q[3]),
      .res_o   (blend_res[c])
    );
  end

  // output stage: scale by depth and saturate
  logic [29:0]     dscaled;
  logic [26:0]     dest_off, src_off;
  logic [3:0][7:0] bytes_out;

  always_comb begin
    unique case (dd3_q)
      3'd3:    dscaled = 30'(dsum3_q) + 30'({dsum3_q, 1'b0});
      3'd4:    dscaled = {dsum3_q, 2'b00};
      default: dscaled = 30'(dsum3_q);
    endcase
    dest_off = (dscaled > 30'(OffsetMax)) ? OffsetMax : dscaled[26:0];
    src_off  = (32'(ssum3_q) > 32'(OffsetMax)) ? OffsetMax : 27'(ssum3_q);
    bytes_out = blend3_q ? {8'h00, blend_res} : bytes3_q;
  end

  logic [26:0]     dest_off_q, src_off_q;
  logic [3:0][7:0] bytes_out_q;
  logic [2:0]      byte_count_q;
  logic            last_q;

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      dest_off_q   <= dest_off;
      src_off_q    <= src_off;
      bytes_out_q  <= bytes_out;
      byte_count_q <= dd3_q;
      last_q       <= last3_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dest_offset_o = dest_off_q;
  assign src_offset_o  = src_off_q;
  assign out_b0_o      = bytes_out_q[0];
  assign out_b1_o      = bytes_out_q[1];
  assign out_b2_o      = bytes_out_q[2];
  assign out_b3_o      = bytes_out_q[3];
  assign byte_count_o  = byte_count_q;
  assign last_o        = last_q;

endmodule
